// ===== rtl/core/dmsbs_pkg.sv =====
// Shared constants, codes and control structs for the depth-map sampler.
// Used by the controller, the datapath and the top level; depends on nothing.
package dmsbs_pkg;

   localparam int DEF_MAX_SIDE = 256;
   localparam int SIDE_REG_W   = 9;
   localparam int DEPTH_W      = 16;

   localparam logic [DEPTH_W-1:0]    FULL_DEPTH = 16'hFFFF;
   localparam logic [SIDE_REG_W-1:0] SIDE_RESET = 9'd256;

   // Operation codes of an input word.
   localparam logic [1:0] OP_WRITE    = 2'd0;
   localparam logic [1:0] OP_NEAREST  = 2'd1;
   localparam logic [1:0] OP_BILINEAR = 2'd2;

   // Register indexes on the configuration port.
   localparam logic REG_MAP_WIDTH  = 1'b0;
   localparam logic REG_MAP_HEIGHT = 1'b1;

   // Texel corner selects, bit 0 steps the column, bit 1 steps the row.
   localparam logic [1:0] CORNER_00 = 2'b00;
   localparam logic [1:0] CORNER_10 = 2'b01;
   localparam logic [1:0] CORNER_01 = 2'b10;
   localparam logic [1:0] CORNER_11 = 2'b11;

   typedef struct packed {
      logic       load;       // latch the accepted input word
      logic       map;        // scale coordinates, clamp indexes
      logic       tex_write;  // store one texel if inside the map
      logic       clear;      // write full depth at the sweep address
      logic       rd_en;      // read the selected corner texel
      logic [1:0] corner;
      logic       cap_a;      // hold the left texel of a pair
      logic       cap_top;    // hold the blended top row
      logic       cap_bot;    // hold the blended bottom row
      logic       near_out;   // present the nearest texel
      logic       fin;        // present the final vertical blend
   } dp_cmd_type;

   typedef struct packed {
      logic clear_done;
   } dp_stat_type;

endpackage

// ===== rtl/core/dmsbs_ram.sv =====
// Generic single-port RAM with registered read data.
// Depends on nothing; instanced for the texel store.
module dmsbs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/dmsbs_ctrl.sv =====
// Sequencer for the depth-map sampler: clearing sweep, writes and sample steps.
// Depends on dmsbs_pkg; drives the datapath through dp_cmd_type.
module dmsbs_ctrl
   import dmsbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [1:0]  req_op,
   output logic        busy,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CLEAR = 4'd1;
   localparam logic [3:0] S_WRITE = 4'd2;
   localparam logic [3:0] S_MAPN  = 4'd3;
   localparam logic [3:0] S_RDN   = 4'd4;
   localparam logic [3:0] S_OUTN  = 4'd5;
   localparam logic [3:0] S_MAPB  = 4'd6;
   localparam logic [3:0] S_RD0   = 4'd7;
   localparam logic [3:0] S_RD1   = 4'd8;
   localparam logic [3:0] S_RD2   = 4'd9;
   localparam logic [3:0] S_RD3   = 4'd10;
   localparam logic [3:0] S_BOT   = 4'd11;
   localparam logic [3:0] S_FIN   = 4'd12;

   logic [3:0] state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               case (req_op)
                  OP_WRITE:    state_in = S_WRITE;
                  OP_NEAREST:  state_in = S_MAPN;
                  OP_BILINEAR: state_in = S_MAPB;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_WRITE: begin
            cmd.tex_write = 1'b1;
            state_in      = S_IDLE;
         end
         S_MAPN: begin
            cmd.map  = 1'b1;
            state_in = S_RDN;
         end
         S_RDN: begin
            cmd.rd_en  = 1'b1;
            cmd.corner = CORNER_00;
            state_in   = S_OUTN;
         end
         S_OUTN: begin
            cmd.near_out = 1'b1;
            state_in     = S_IDLE;
         end
         S_MAPB: begin
            cmd.map  = 1'b1;
            state_in = S_RD0;
         end
         S_RD0: begin
            cmd.rd_en  = 1'b1;
            cmd.corner = CORNER_00;
            state_in   = S_RD1;
         end
         S_RD1: begin
            cmd.rd_en  = 1'b1;
            cmd.corner = CORNER_10;
            cmd.cap_a  = 1'b1;
            state_in   = S_RD2;
         end
         S_RD2: begin
            cmd.rd_en   = 1'b1;
            cmd.corner  = CORNER_01;
            cmd.cap_top = 1'b1;
            state_in    = S_RD3;
         end
         S_RD3: begin
            cmd.rd_en  = 1'b1;
            cmd.corner = CORNER_11;
            cmd.cap_a  = 1'b1;
            state_in   = S_BOT;
         end
         S_BOT: begin
            cmd.cap_bot = 1'b1;
            state_in    = S_FIN;
         end
         S_FIN: begin
            cmd.fin  = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/dmsbs_dp.sv =====
// Datapath of the depth-map sampler: coordinate mapping, texel store access
// and the shared blend unit. Depends on dmsbs_pkg and dmsbs_ram.
module dmsbs_dp
   import dmsbs_pkg::*;
#(
   parameter int MAX_SIDE = DEF_MAX_SIDE
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_stat_type           stat,
   input  logic [SIDE_REG_W-1:0] map_width,
   input  logic [SIDE_REG_W-1:0] map_height,
   input  logic [1:0]            req_op,
   input  logic [7:0]            req_write_col,
   input  logic [7:0]            req_write_row,
   input  logic [DEPTH_W-1:0]    req_write_depth,
   input  logic [15:0]           req_sample_u,
   input  logic [15:0]           req_sample_v,
   output logic                  rsp_valid,
   output logic [DEPTH_W-1:0]    rsp_sampled_depth
);

   localparam int ADDR_W = $clog2(MAX_SIDE * MAX_SIDE);
   localparam int TU_W   = 16 + SIDE_REG_W;

   logic [1:0]            op_ff;
   logic [7:0]            col_ff, row_ff;
   logic [DEPTH_W-1:0]    wdepth_ff;
   logic [15:0]           u_ff, v_ff;
   logic [SIDE_REG_W-1:0] x_ff, y_ff;
   logic [15:0]           fx_ff, fy_ff;
   logic [DEPTH_W-1:0]    a_ff, top_ff, bot_ff;
   logic [ADDR_W-1:0]     clr_cnt_ff;
   logic                  rsp_valid_ff;
   logic [DEPTH_W-1:0]    rsp_depth_ff;

   logic [SIDE_REG_W-1:0] w_eff, h_eff, x_lim, y_lim, x_in, y_in, xa, ya;
   logic [TU_W-1:0]       tu, tv;
   logic                  in_bounds, ram_we, ram_en;
   logic [ADDR_W-1:0]     ram_addr;
   logic [DEPTH_W-1:0]    ram_wdata, ram_rdata;

   logic [DEPTH_W-1:0]    bl_lo, bl_hi, blend_q;
   logic [15:0]           bl_f;
   logic signed [16:0]    bl_diff;
   logic signed [33:0]    bl_prod, bl_acc;

   // Register values outside 2..MAX_SIDE are pinned to the nearest bound.
   always_comb begin
      if (map_width < 9'd2) begin
         w_eff = 9'd2;
      end else if (32'(map_width) > MAX_SIDE) begin
         w_eff = SIDE_REG_W'(MAX_SIDE);
      end else begin
         w_eff = map_width;
      end
      if (map_height < 9'd2) begin
         h_eff = 9'd2;
      end else if (32'(map_height) > MAX_SIDE) begin
         h_eff = SIDE_REG_W'(MAX_SIDE);
      end else begin
         h_eff = map_height;
      end
   end

   // Index is the clamped integer part of coord*side; fraction unclamped.
   always_comb begin
      tu = TU_W'(u_ff) * TU_W'(w_eff);
      tv = TU_W'(v_ff) * TU_W'(h_eff);
      if (op_ff == OP_BILINEAR) begin
         x_lim = w_eff - 9'd2;
         y_lim = h_eff - 9'd2;
      end else begin
         x_lim = w_eff - 9'd1;
         y_lim = h_eff - 9'd1;
      end
      x_in = (tu[TU_W-1:16] > x_lim) ? x_lim : tu[TU_W-1:16];
      y_in = (tv[TU_W-1:16] > y_lim) ? y_lim : tv[TU_W-1:16];
   end

   assign in_bounds = ({1'b0, col_ff} < w_eff) && ({1'b0, row_ff} < h_eff);

   always_comb begin
      xa = x_ff + {{(SIDE_REG_W-1){1'b0}}, cmd.corner[0]};
      ya = y_ff + {{(SIDE_REG_W-1){1'b0}}, cmd.corner[1]};
      ram_we    = cmd.clear || (cmd.tex_write && in_bounds);
      ram_en    = ram_we || cmd.rd_en;
      ram_wdata = cmd.clear ? FULL_DEPTH : wdepth_ff;
      if (cmd.clear) begin
         ram_addr = clr_cnt_ff;
      end else if (cmd.tex_write) begin
         ram_addr = ADDR_W'(col_ff) * ADDR_W'(MAX_SIDE) + ADDR_W'(row_ff);
      end else begin
         ram_addr = ADDR_W'(xa) * ADDR_W'(MAX_SIDE) + ADDR_W'(ya);
      end
   end

   dmsbs_ram #(
      .WIDTH (DEPTH_W),
      .DEPTH (MAX_SIDE * MAX_SIDE)
   ) u_store (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // lo*(1-f) + hi*f is computed as (lo << 16) + (hi - lo)*f, then truncated.
   always_comb begin
      bl_lo   = cmd.fin ? top_ff : a_ff;
      bl_hi   = cmd.fin ? bot_ff : ram_rdata;
      bl_f    = cmd.fin ? fy_ff : fx_ff;
      bl_diff = $signed({1'b0, bl_hi}) - $signed({1'b0, bl_lo});
      bl_prod = 34'(bl_diff) * $signed({18'd0, bl_f});
      bl_acc  = bl_prod + $signed({2'b00, bl_lo, 16'h0000});
      blend_q = bl_acc[31:16];
   end

   // The sweep ends on the last texel of the store.
   assign stat.clear_done = (clr_cnt_ff == ADDR_W'(MAX_SIDE * MAX_SIDE - 1));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_op;
         col_ff    <= req_write_col;
         row_ff    <= req_write_row;
         wdepth_ff <= req_write_depth;
         u_ff      <= req_sample_u;
         v_ff      <= req_sample_v;
      end
      if (cmd.map) begin
         x_ff  <= x_in;
         y_ff  <= y_in;
         fx_ff <= tu[15:0];
         fy_ff <= tv[15:0];
      end
      if (cmd.cap_a) begin
         a_ff <= ram_rdata;
      end
      if (cmd.cap_top) begin
         top_ff <= blend_q;
      end
      if (cmd.cap_bot) begin
         bot_ff <= blend_q;
      end
      if (cmd.near_out) begin
         rsp_depth_ff <= ram_rdata;
      end else if (cmd.fin) begin
         rsp_depth_ff <= blend_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         rsp_valid_ff <= cmd.near_out || cmd.fin;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sampled_depth = rsp_depth_ff;

endmodule

// ===== rtl/core/depth_map_store_bilinear_sampler.sv =====
// Top level of the depth-map store with nearest and bilinear sampling.
// Depends on dmsbs_pkg, dmsbs_ctrl and dmsbs_dp (which holds dmsbs_ram).
//
// Usage. A command word is taken at a rising edge where start is high and
// busy is low. req_op selects a texel write, a nearest sample or a bilinear
// sample; an unused op code is taken and dropped. Texel writes outside the
// current map size are ignored and give no result. Each sample returns one
// word on rsp_sampled_depth, marked by rsp_valid for exactly one cycle; the
// receiver must take it then, since it cannot hold results off.
// Sequence. A write passes through its store write state after acceptance.
// A nearest sample passes through mapping, one store read and output, and
// a bilinear sample through mapping, four store reads, the bottom-row blend
// and the final blend; busy drops in the result cycle and the next word is
// taken at the edge that ends it, so each word waits for the previous one.
// The bilinear sequence is set by the four reads from the single-port
// texel store plus coordinate mapping and blending.
// Reset. After reset the block sweeps the whole store to full depth, one
// texel per cycle, with busy high. Map width and height return to 256 and
// may be written over the register port while no word is in flight,
// including during the sweep.
module depth_map_store_bilinear_sampler
   import dmsbs_pkg::*;
#(
   parameter int MAX_SIDE = DEF_MAX_SIDE
) (
   input  logic               clock,
   input  logic               reset,
   // Command channel.
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_op,
   input  logic [7:0]         req_write_col,
   input  logic [7:0]         req_write_row,
   input  logic [15:0]        req_write_depth,
   input  logic [15:0]        req_sample_u,
   input  logic [15:0]        req_sample_v,
   // Result channel.
   output logic               rsp_valid,
   output logic [15:0]        rsp_sampled_depth,
   // Register port.
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic [SIDE_REG_W-1:0] map_width_ff, map_height_ff;
   logic                  csr_wr;
   logic                  reg_sel;
   dp_cmd_type            cmd;
   dp_stat_type           stat;

   // Registers sit on word addresses; the word index is address bit 2.
   assign pready  = 1'b1;
   assign reg_sel = paddr[2];
   assign csr_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= SIDE_RESET;
         map_height_ff <= SIDE_RESET;
      end else if (csr_wr) begin
         if (reg_sel == REG_MAP_WIDTH) begin
            map_width_ff <= pwdata[SIDE_REG_W-1:0];
         end else begin
            map_height_ff <= pwdata[SIDE_REG_W-1:0];
         end
      end
   end

   always_comb begin
      if (reg_sel == REG_MAP_WIDTH) begin
         prdata = {{(32-SIDE_REG_W){1'b0}}, map_width_ff};
      end else begin
         prdata = {{(32-SIDE_REG_W){1'b0}}, map_height_ff};
      end
   end

   // The sequencer steps each command through the datapath, at most one texel
   // store access per cycle.
   dmsbs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .busy   (busy),
      .stat   (stat),
      .cmd    (cmd)
   );

   dmsbs_dp #(
      .MAX_SIDE (MAX_SIDE)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .map_width         (map_width_ff),
      .map_height        (map_height_ff),
      .req_op            (req_op),
      .req_write_col     (req_write_col),
      .req_write_row     (req_write_row),
      .req_write_depth   (req_write_depth),
      .req_sample_u      (req_sample_u),
      .req_sample_v      (req_sample_v),
      .rsp_valid         (rsp_valid),
      .rsp_sampled_depth (rsp_sampled_depth)
   );

endmodule
